/* sv/wtm_pkg.sv */
// Shared types and constants for the windowed traffic meter.
`default_nettype none

package wtm_pkg;

  localparam int unsigned WindowSecondsDef = 16;
  localparam int unsigned TimeW            = 32;
  localparam int unsigned BytesW           = 16;
  localparam int unsigned TotalW           = 48;
  localparam int unsigned SumW             = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_MOD,
    ST_RD,
    ST_WR,
    ST_SUM,
    ST_SUMLAST,
    ST_DIVIN,
    ST_DIVOUT,
    ST_OUT
  } wtm_state_e;

  typedef enum logic {
    REQ_RECORD = 1'b0,
    REQ_QUERY  = 1'b1
  } wtm_req_e;

endpackage

`default_nettype wire

/* sv/wtm_cdiv.sv */
// Divider by a constant: reciprocal multiply, back-multiply and one correction step.
`default_nettype none

module wtm_cdiv import wtm_pkg::*; #(
  parameter int unsigned Divisor = WindowSecondsDef,
  localparam int unsigned RemW   = (Divisor > 1) ? $clog2(Divisor) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [SumW-1:0] dividend_i,
  output logic                 done_o,
  output logic [SumW-1:0]      quotient_o,
  output logic [RemW-1:0]      remainder_o
);

  // floor(2^32 / Divisor): the quotient estimate is exact or one short
  localparam logic [SumW-1:0] Recip = SumW'((64'd1 << SumW) / 64'(Divisor));
  localparam logic [RemW:0]   DivK  = (RemW + 1)'(Divisor);

  logic [SumW-1:0]   dvd_q;
  logic [SumW-1:0]   qest_q;
  logic [RemW:0]     rest_q;
  logic [SumW-1:0]   quo_q;
  logic [RemW-1:0]   rem_q;
  logic [2:0]        stage_q;
  logic              done_q;
  logic [2*SumW-1:0] prod;
  logic [SumW-1:0]   back;
  logic [RemW:0]     rest_fix;

  assign prod     = (2*SumW)'(dvd_q) * (2*SumW)'(Recip);
  assign back     = qest_q * SumW'(Divisor);
  assign rest_fix = rest_q - DivK;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
      done_q  <= 1'b0;
    end else begin
      stage_q <= {stage_q[1:0], start_i};
      done_q  <= stage_q[2];
    end
  end

  // remainder estimate stays below twice the divisor
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
    end
    if (stage_q[0]) begin
      qest_q <= prod[2*SumW-1:SumW];
    end
    if (stage_q[1]) begin
      rest_q <= (RemW + 1)'(dvd_q - back);
    end
    if (stage_q[2]) begin
      if (rest_q >= DivK) begin
        quo_q <= qest_q + 1'b1;
        rem_q <= rest_fix[RemW-1:0];
      end else begin
        quo_q <= qest_q;
        rem_q <= rest_q[RemW-1:0];
      end
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

/* sv/wtm_ring.sv */
// One ring of per-second byte buckets: memory plus per-entry valid bits.
`default_nettype none

module wtm_ring import wtm_pkg::*; #(
  parameter int unsigned Depth = WindowSecondsDef,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             clr_en_i,
  input  wire logic [AddrW-1:0] clr_addr_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [SumW-1:0]  rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [SumW-1:0]  wr_data_i
);

  logic [SumW-1:0]  mem_q [Depth];
  logic [Depth-1:0] vld_q;
  logic [SumW-1:0]  rd_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // a bucket that is not valid reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (clr_en_i) begin
        vld_q[clr_addr_i] <= 1'b0;
      end
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

/* sv/windowed_traffic_meter.sv */
// Top level of the windowed traffic meter: sequencer, totals and result register.
`default_nettype none

// Meters incoming and outgoing bytes over a sliding window of WINDOW_SECONDS
// one-second buckets. Each item first clears the buckets of the seconds after
// the last recorded second up to now (at most the whole window), then a record
// item adds its byte counts to the 48-bit lifetime totals and to the bucket of
// now_seconds; every item returns totals, window sums and per-second averages.
// Items are taken one at a time. A single constant divider (reciprocal
// multiply with one correction) yields the bucket index and both averages,
// and the rings are read one bucket a cycle. A finished result waits in the
// output register while the next item is taken.
module windowed_traffic_meter import wtm_pkg::*; #(
  parameter int unsigned WINDOW_SECONDS = WindowSecondsDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // now_seconds[31:0], bytes_received[47:32], bytes_sent[63:48]
  input  wire logic [63:0]  s_axis_tdata_i,
  // req_type[0]
  input  wire logic [0:0]   s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // lifetime_in[47:0], lifetime_out[95:48], window_in_sum[127:96],
  // window_out_sum[159:128], rate_in[191:160], rate_out[223:192]
  output logic [223:0]      m_axis_tdata_o
);

  localparam int unsigned AW = $clog2(WINDOW_SECONDS);
  localparam int unsigned CW = $clog2(WINDOW_SECONDS + 1);

  wtm_state_e state_q, state_d;

  wtm_req_e            req_q;
  logic [TimeW-1:0]    now_q;
  logic [BytesW-1:0]   rx_q, tx_q;
  logic [CW-1:0]       cnt_q;
  logic [AW-1:0]       ptr_q, ptr_inc;
  logic [AW-1:0]       slot_q, idx_q;
  logic [TimeW-1:0]    last_second_q;
  logic [AW-1:0]       last_slot_q;
  logic [TotalW-1:0]   total_in_q, total_out_q;
  logic [SumW-1:0]     sum_in_q, sum_out_q, sum_in_d, sum_out_d;
  logic                acc_en_q;
  logic [SumW-1:0]     rate_in_q, rate_out_q;
  logic                out_valid_q;
  logic [223:0]        out_data_q;

  logic                in_accept;
  logic                out_free;
  logic [TimeW-1:0]    gap;
  logic [CW-1:0]       cnt_init;

  logic                div_start, div_done;
  logic [SumW-1:0]     div_dividend, div_quo;
  logic [AW-1:0]       div_rem;

  logic                clr_en, rd_en, wr_en;
  logic [AW-1:0]       rd_addr;
  logic [SumW-1:0]     in_rd_data, out_rd_data, in_wr_data, out_wr_data;

  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !out_valid_q || m_axis_tready_i;

  // wrapping gap since the last record, capped at the window
  assign gap      = s_axis_tdata_i[31:0] - last_second_q;
  assign cnt_init = (gap < TimeW'(WINDOW_SECONDS)) ? CW'(gap) : CW'(WINDOW_SECONDS);

  assign ptr_inc = (ptr_q == AW'(WINDOW_SECONDS - 1)) ? '0 : ptr_q + 1'b1;

  assign sum_in_d  = acc_en_q ? sum_in_q + in_rd_data : sum_in_q;
  assign sum_out_d = acc_en_q ? sum_out_q + out_rd_data : sum_out_q;

  assign in_wr_data  = in_rd_data + SumW'(rx_q);
  assign out_wr_data = out_rd_data + SumW'(tx_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_accept) state_d = ST_CLEAR;
      ST_CLEAR: begin
        if (cnt_q == '0) begin
          state_d = (req_q == REQ_QUERY) ? ST_SUM : ST_MOD;
        end
      end
      ST_MOD:     if (div_done) state_d = ST_RD;
      ST_RD:      state_d = ST_WR;
      ST_WR:      state_d = ST_SUM;
      ST_SUM:     if (idx_q == AW'(WINDOW_SECONDS - 1)) state_d = ST_SUMLAST;
      ST_SUMLAST: state_d = ST_DIVIN;
      ST_DIVIN:   if (div_done) state_d = ST_DIVOUT;
      ST_DIVOUT:  if (div_done) state_d = ST_OUT;
      ST_OUT:     if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    clr_en          = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = idx_q;
    wr_en           = 1'b0;
    div_start       = 1'b0;
    div_dividend    = now_q;
    unique case (state_q)
      ST_IDLE:  s_axis_tready_o = 1'b1;
      ST_CLEAR: begin
        clr_en    = (cnt_q != '0);
        div_start = (cnt_q == '0) && (req_q == REQ_RECORD);
      end
      ST_RD: begin
        rd_en   = 1'b1;
        rd_addr = slot_q;
      end
      ST_WR:  wr_en = 1'b1;
      ST_SUM: rd_en = 1'b1;
      ST_SUMLAST: begin
        div_start    = 1'b1;
        div_dividend = sum_in_d;
      end
      ST_DIVIN: begin
        div_start    = div_done;
        div_dividend = sum_out_q;
      end
      ST_MOD, ST_DIVOUT, ST_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      ptr_q         <= '0;
      idx_q         <= '0;
      acc_en_q      <= 1'b0;
      last_second_q <= '0;
      last_slot_q   <= '0;
      total_in_q    <= '0;
      total_out_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      acc_en_q <= (state_q == ST_SUM);
      if (in_accept) begin
        cnt_q <= cnt_init;
        ptr_q <= last_slot_q;
        idx_q <= '0;
      end
      if (clr_en) begin
        ptr_q <= ptr_inc;
        cnt_q <= cnt_q - 1'b1;
      end
      if (state_q == ST_SUM) begin
        idx_q <= idx_q + 1'b1;
      end
      if (wr_en) begin
        total_in_q    <= total_in_q + TotalW'(rx_q);
        total_out_q   <= total_out_q + TotalW'(tx_q);
        last_second_q <= now_q;
        last_slot_q   <= slot_q;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q    <= wtm_req_e'(s_axis_tuser_i[0]);
      now_q    <= s_axis_tdata_i[31:0];
      rx_q     <= s_axis_tdata_i[47:32];
      tx_q     <= s_axis_tdata_i[63:48];
      sum_in_q  <= '0;
      sum_out_q <= '0;
    end else begin
      sum_in_q  <= sum_in_d;
      sum_out_q <= sum_out_d;
    end
    if (state_q == ST_MOD && div_done) begin
      slot_q <= div_rem;
    end
    if (state_q == ST_DIVIN && div_done) begin
      rate_in_q <= div_quo;
    end
    if (state_q == ST_DIVOUT && div_done) begin
      rate_out_q <= div_quo;
    end
    if (state_q == ST_OUT && out_free) begin
      out_data_q <= {rate_out_q, rate_in_q, sum_out_q, sum_in_q, total_out_q, total_in_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  wtm_cdiv #(
    .Divisor (WINDOW_SECONDS)
  ) u_cdiv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  wtm_ring #(
    .Depth (WINDOW_SECONDS)
  ) u_ring_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_en_i   (clr_en),
    .clr_addr_i (ptr_inc),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (in_rd_data),
    .wr_en_i    (wr_en),
    .wr_addr_i  (slot_q),
    .wr_data_i  (in_wr_data)
  );

  wtm_ring #(
    .Depth (WINDOW_SECONDS)
  ) u_ring_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_en_i   (clr_en),
    .clr_addr_i (ptr_inc),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (out_rd_data),
    .wr_en_i    (wr_en),
    .wr_addr_i  (slot_q),
    .wr_data_i  (out_wr_data)
  );

  a_cnt_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(WINDOW_SECONDS))
    else $error("stale count beyond window");

  a_query_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR) |-> (req_q == REQ_RECORD))
    else $error("bucket write on a query item");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_MOD || state_q == ST_DIVIN || state_q == ST_DIVOUT))
    else $error("divider result in a state that does not wait for it");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && !out_free) |=> (state_q == ST_OUT && $stable(rate_in_q)))
    else $error("finished item lost while output stalled");

endmodule

`default_nettype wire
